[design/tdc_edge_hit_classifier_unit_defines.svh]
// ----------------------------------------------------------------------------
// TDC edge hit classifier assertion macros
// Shared assertion helpers; clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TDC_EDGE_HIT_CLASSIFIER_UNIT_DEFINES_SVH
`define TDC_EDGE_HIT_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TDCHC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TDCHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tdchc_pkg.sv]
// ----------------------------------------------------------------------------
// TDC edge hit classifier package
// Shared constants and the hit class encoding.
// ----------------------------------------------------------------------------
package tdchc_pkg;

    localparam int CHANNELS_DEF  = 192;
    localparam int TIME_BITS_DEF = 13;

    localparam int COUNT_W = 8;
    localparam int SKIP_W  = 16;
    localparam int PW_W    = 14;
    localparam int TID_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
    localparam logic [SKIP_W-1:0]  SKIP_RESET = 16'd2;

    typedef enum logic [2:0] {
        CLS_EMPTY    = 3'd0,
        CLS_NOISY    = 3'd1,
        CLS_SINGLE   = 3'd2,
        CLS_MULTIPLE = 3'd3,
        CLS_SKIPPED  = 3'd4
    } hit_class_t;

    typedef enum logic {
        KIND_EDGE   = 1'b0,
        KIND_REPORT = 1'b1
    } item_kind_t;

    typedef enum logic {
        POL_RISE = 1'b0,
        POL_FALL = 1'b1
    } edge_pol_t;

endpackage

[design/tdchc_store.sv]
// ----------------------------------------------------------------------------
// TDC hit classifier channel store
// Per-channel counts and latest edge times in a memory with registered read,
// per-entry valid bits for reset, and a bypass for a write to the entry
// being read in the same cycle.
// ----------------------------------------------------------------------------
module tdchc_store
    import tdchc_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int CH_W      = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [CH_W-1:0]      rd_idx,
    input  logic                 wr_en,
    input  logic [CH_W-1:0]      wr_idx,
    input  logic [COUNT_W-1:0]   wr_rise_cnt,
    input  logic [COUNT_W-1:0]   wr_fall_cnt,
    input  logic [TIME_BITS-1:0] wr_rise_time,
    input  logic [TIME_BITS-1:0] wr_fall_time,
    output logic [COUNT_W-1:0]   rise_cnt,
    output logic [COUNT_W-1:0]   fall_cnt,
    output logic [TIME_BITS-1:0] rise_time,
    output logic [TIME_BITS-1:0] fall_time
);

    localparam int EW = 2 * COUNT_W + 2 * TIME_BITS;

    logic [EW-1:0]       mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;
    logic [EW-1:0]       rd_data_reg;
    logic [CH_W-1:0]     rd_idx_reg;
    logic                byp_reg;
    logic [EW-1:0]       byp_data_reg;
    logic [EW-1:0]       wr_data;
    logic [EW-1:0]       entry;

    assign wr_data = {wr_rise_cnt, wr_fall_cnt, wr_rise_time, wr_fall_time};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_idx];
            rd_idx_reg   <= rd_idx;
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            byp_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                byp_reg <= wr_en && (wr_idx == rd_idx);
            end
        end
    end

    // Write in the read cycle lands after the read: take it from the bypass.
    always_comb
    begin
        if (byp_reg)
        begin
            entry = byp_data_reg;
        end
        else if (vld_reg[rd_idx_reg])
        begin
            entry = rd_data_reg;
        end
        else
        begin
            entry = '0;
        end
    end

    assign {rise_cnt, fall_cnt, rise_time, fall_time} = entry;

endmodule

[design/tdchc_classify.sv]
// ----------------------------------------------------------------------------
// TDC hit classifier update and classification
// Computes the updated channel entry for an edge or a report, the hit class
// and the pulse width.
// ----------------------------------------------------------------------------
module tdchc_classify
    import tdchc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  item_kind_t           kind,
    input  edge_pol_t            polarity,
    input  logic [TIME_BITS-1:0] edge_time,
    input  logic                 skip,
    input  logic [COUNT_W-1:0]   rise_cnt,
    input  logic [COUNT_W-1:0]   fall_cnt,
    input  logic [TIME_BITS-1:0] rise_time,
    input  logic [TIME_BITS-1:0] fall_time,
    output logic                 wr_en,
    output logic [COUNT_W-1:0]   new_rise_cnt,
    output logic [COUNT_W-1:0]   new_fall_cnt,
    output logic [TIME_BITS-1:0] new_rise_time,
    output logic [TIME_BITS-1:0] new_fall_time,
    output hit_class_t           hit_class,
    output logic [PW_W-1:0]      pulse_width
);

    localparam int DW = (TIME_BITS + 1 > PW_W) ? TIME_BITS + 1 : PW_W;

    logic [DW-1:0]      diff;
    logic [COUNT_W-1:0] rise_inc;
    logic [COUNT_W-1:0] fall_inc;

    // Modular difference; its low bits match the sign-extended width.
    assign diff     = DW'(fall_time) - DW'(rise_time);
    assign rise_inc = (rise_cnt == COUNT_MAX) ? rise_cnt : rise_cnt + 1'b1;
    assign fall_inc = (fall_cnt == COUNT_MAX) ? fall_cnt : fall_cnt + 1'b1;

    always_comb
    begin
        if (skip)
        begin
            hit_class = CLS_SKIPPED;
        end
        else if (rise_cnt == '0 && fall_cnt == '0)
        begin
            hit_class = CLS_EMPTY;
        end
        else if (rise_cnt != fall_cnt)
        begin
            hit_class = CLS_NOISY;
        end
        else if (rise_cnt == COUNT_W'(1))
        begin
            hit_class = CLS_SINGLE;
        end
        else
        begin
            hit_class = CLS_MULTIPLE;
        end
    end

    assign pulse_width = (hit_class == CLS_SINGLE) ? diff[PW_W-1:0] : '0;

    always_comb
    begin
        new_rise_cnt  = rise_cnt;
        new_fall_cnt  = fall_cnt;
        new_rise_time = rise_time;
        new_fall_time = fall_time;
        wr_en         = 1'b1;
        unique case (kind)
            KIND_EDGE:
            begin
                if (polarity == POL_RISE)
                begin
                    new_rise_cnt  = rise_inc;
                    new_rise_time = edge_time;
                end
                else
                begin
                    new_fall_cnt  = fall_inc;
                    new_fall_time = edge_time;
                end
            end
            KIND_REPORT:
            begin
                // A skipped report keeps the entry for a later readout.
                wr_en         = !skip;
                new_rise_cnt  = '0;
                new_fall_cnt  = '0;
                new_rise_time = '0;
                new_fall_time = '0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

[design/tdc_edge_hit_classifier_unit.sv]
// ----------------------------------------------------------------------------
// TDC edge hit classifier
// Takes one item per clock while busy is low: an edge item updates one
// channel's counts and latest edge time, a report item reads one channel,
// classifies it and clears it unless it is skipped. result_valid follows
// the start transfer through the stage-one registers with the registered
// read of the channel memory, then the result register; a bypass keeps
// back-to-back items on the same channel correct. The receiver cannot stall:
// each result is present for exactly one cycle. Items on channels at or above
// CHANNELS give no result. Reset clears all entries at once through
// per-channel valid bits; busy is high only for the first cycle after reset.
// ----------------------------------------------------------------------------
`include "tdc_edge_hit_classifier_unit_defines.svh"

module tdc_edge_hit_classifier_unit
    import tdchc_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [7:0]           channel,
    input  logic [TIME_BITS-1:0] edge_time,
    input  logic                 polarity,
    input  logic [TID_W-1:0]     trigger_id,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SKIP_W-1:0]    cfg_data,
    output logic                 result_valid,
    output logic [7:0]           report_channel,
    output logic [COUNT_W-1:0]   rise_total,
    output logic [COUNT_W-1:0]   fall_total,
    output logic [2:0]           hit_class,
    output logic [PW_W-1:0]      pulse_width
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                 accept;
    logic                 in_range;
    logic                 busy_reg;
    logic [SKIP_W-1:0]    skip_below_reg;

    logic                 s1_valid_reg;
    item_kind_t           s1_kind_reg;
    edge_pol_t            s1_pol_reg;
    logic [CH_W-1:0]      s1_idx_reg;
    logic [7:0]           s1_chan_reg;
    logic [TIME_BITS-1:0] s1_time_reg;
    logic                 s1_skip_reg;

    logic [COUNT_W-1:0]   ent_rise_cnt;
    logic [COUNT_W-1:0]   ent_fall_cnt;
    logic [TIME_BITS-1:0] ent_rise_time;
    logic [TIME_BITS-1:0] ent_fall_time;
    logic                 upd_wr_en;
    logic [COUNT_W-1:0]   upd_rise_cnt;
    logic [COUNT_W-1:0]   upd_fall_cnt;
    logic [TIME_BITS-1:0] upd_rise_time;
    logic [TIME_BITS-1:0] upd_fall_time;
    hit_class_t           cls;
    logic [PW_W-1:0]      width;

    logic                 res_valid_reg;
    logic [7:0]           res_chan_reg;
    logic [COUNT_W-1:0]   res_rise_reg;
    logic [COUNT_W-1:0]   res_fall_reg;
    hit_class_t           res_class_reg;
    logic [PW_W-1:0]      res_width_reg;

    assign accept    = start && !busy_reg;
    assign in_range  = 32'(channel) < 32'(CHANNELS);
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            skip_below_reg <= SKIP_RESET;
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid)
            begin
                skip_below_reg <= cfg_data;
            end
            s1_valid_reg  <= accept && in_range;
            res_valid_reg <= s1_valid_reg && (s1_kind_reg == KIND_REPORT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= item_kind_t'(kind);
            s1_pol_reg  <= edge_pol_t'(polarity);
            s1_idx_reg  <= CH_W'(channel);
            s1_chan_reg <= channel;
            s1_time_reg <= edge_time;
            s1_skip_reg <= trigger_id < TID_W'(skip_below_reg);
        end
        res_chan_reg  <= s1_chan_reg;
        res_rise_reg  <= ent_rise_cnt;
        res_fall_reg  <= ent_fall_cnt;
        res_class_reg <= cls;
        res_width_reg <= width;
    end

    tdchc_store #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS),
        .CH_W      (CH_W)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_en        (accept && in_range),
        .rd_idx       (CH_W'(channel)),
        .wr_en        (s1_valid_reg && upd_wr_en),
        .wr_idx       (s1_idx_reg),
        .wr_rise_cnt  (upd_rise_cnt),
        .wr_fall_cnt  (upd_fall_cnt),
        .wr_rise_time (upd_rise_time),
        .wr_fall_time (upd_fall_time),
        .rise_cnt     (ent_rise_cnt),
        .fall_cnt     (ent_fall_cnt),
        .rise_time    (ent_rise_time),
        .fall_time    (ent_fall_time)
    );

    tdchc_classify #(
        .TIME_BITS (TIME_BITS)
    ) u_classify (
        .kind          (s1_kind_reg),
        .polarity      (s1_pol_reg),
        .edge_time     (s1_time_reg),
        .skip          (s1_skip_reg),
        .rise_cnt      (ent_rise_cnt),
        .fall_cnt      (ent_fall_cnt),
        .rise_time     (ent_rise_time),
        .fall_time     (ent_fall_time),
        .wr_en         (upd_wr_en),
        .new_rise_cnt  (upd_rise_cnt),
        .new_fall_cnt  (upd_fall_cnt),
        .new_rise_time (upd_rise_time),
        .new_fall_time (upd_fall_time),
        .hit_class     (cls),
        .pulse_width   (width)
    );

    assign result_valid   = res_valid_reg;
    assign report_channel = res_chan_reg;
    assign rise_total     = res_rise_reg;
    assign fall_total     = res_fall_reg;
    assign hit_class      = res_class_reg;
    assign pulse_width    = res_width_reg;

    `TDCHC_ASSERT_NEXT(a_report_gives_result, s1_valid_reg && (s1_kind_reg == KIND_REPORT),
        result_valid, "accepted report produced no result")
    `TDCHC_ASSERT_NEXT(a_edge_gives_none, s1_valid_reg && (s1_kind_reg == KIND_EDGE),
        !result_valid, "edge item produced a result")
    `TDCHC_ASSERT_SAME(a_width_only_single, result_valid && (hit_class != CLS_SINGLE),
        pulse_width == '0, "nonzero pulse width outside a single hit")
    `TDCHC_ASSERT_SAME(a_single_counts, result_valid && (hit_class == CLS_SINGLE),
        (rise_total == COUNT_W'(1)) && (fall_total == COUNT_W'(1)),
        "single hit without one rise and one fall")

endmodule
